>>> rtl/core/atc_pkg.sv
// Shared constants, types and codes for the associative tag cache.
package atc_pkg;

    // Store geometry.
    localparam int ENTRIES    = 16;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int ENTRIES_P2 = 2 ** IDX_W;

    // Field widths.
    localparam int KEY_W  = 64;
    localparam int SIZE_W = 17;
    localparam int SLOT_W = 4;
    localparam int AGE_W  = 8;

    // Inserts at or above this byte count are dropped.
    localparam int SIZE_LIMIT = 102400;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [AGE_W-1:0]  age_t;
    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [SIZE_W-1:0] size_t;
    typedef logic [SLOT_W-1:0] slot_t;

    localparam age_t AGE_TOP = '1;

    // Request codes.
    typedef enum logic [0:0] {
        OP_LOOKUP = 1'b0,
        OP_INSERT = 1'b1
    } op_t;

    // Replacement choice handed from the victim selector to the store.
    typedef struct packed {
        logic from_empty;
        idx_t idx;
    } victim_t;

endpackage

>>> rtl/core/atc_victim_sel.sv
// Victim selection: first empty slot, else the oldest slot (lowest index on a tie).
module atc_victim_sel (
    input  logic [atc_pkg::ENTRIES-1:0] valid_i,
    input  atc_pkg::age_t               ages_i [atc_pkg::ENTRIES],
    output atc_pkg::victim_t            victim_o
);

    localparam int LVL = atc_pkg::IDX_W;

    atc_pkg::age_t tree_age [LVL+1][atc_pkg::ENTRIES_P2];
    atc_pkg::idx_t tree_idx [LVL+1][atc_pkg::ENTRIES_P2];
    atc_pkg::idx_t empty_idx;

    // Lowest-indexed empty slot.
    always_comb begin
        empty_idx = '0;
        for (int i = atc_pkg::ENTRIES - 1; i >= 0; i--) begin
            if (!valid_i[i]) begin
                empty_idx = atc_pkg::IDX_W'(i);
            end
        end
    end

    // Max-age tree; the left branch wins ties so the lowest index is kept.
    // Padding leaves sit at the top and hold age zero, so they never win.
    always_comb begin
        for (int j = 0; j < atc_pkg::ENTRIES_P2; j++) begin
            tree_idx[0][j] = atc_pkg::IDX_W'(j);
            if (j < atc_pkg::ENTRIES) begin
                tree_age[0][j] = ages_i[j];
            end else begin
                tree_age[0][j] = '0;
            end
        end
        for (int l = 1; l <= LVL; l++) begin
            for (int j = 0; j < atc_pkg::ENTRIES_P2; j++) begin
                if (j < (atc_pkg::ENTRIES_P2 >> l)) begin
                    if (tree_age[l-1][2*j+1] > tree_age[l-1][2*j]) begin
                        tree_age[l][j] = tree_age[l-1][2*j+1];
                        tree_idx[l][j] = tree_idx[l-1][2*j+1];
                    end else begin
                        tree_age[l][j] = tree_age[l-1][2*j];
                        tree_idx[l][j] = tree_idx[l-1][2*j];
                    end
                end else begin
                    tree_age[l][j] = '0;
                    tree_idx[l][j] = '0;
                end
            end
        end
    end

    // An empty slot always takes precedence over the oldest one.
    always_comb begin
        victim_o.from_empty = ~&valid_i;
        victim_o.idx        = victim_o.from_empty ? empty_idx : tree_idx[LVL][0];
    end

endmodule

>>> rtl/core/assoc_tag_cache_fifo_replace_top.sv
// Top level of the fully associative tag cache with age-based replacement.
//
//  Channel | Dir | Ports                                       | Handshake
//  --------+-----+---------------------------------------------+-------------
//  s_      | in  | s_operation, s_key, s_object_size           | s_valid/s_ready
//  m_      | out | m_hit, m_slot, m_found_size                 | m_valid/m_ready
//
// One beat per cycle sustained while m_ready stays high. A request's beat is
// captured in the input register and its result in the result register, which
// presents it on m_. The whole tag compare, victim search and store update sit
// between those two registers, so each request sees every update made by the
// one before it.
// Reset clears the valid marks; the store is then empty.
// When m_ready is low the result register holds, the input register fills
// behind it, and s_ready drops until the result beat is taken.
module assoc_tag_cache_fifo_replace_top (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_operation,
    input  atc_pkg::key_t         s_key,
    input  atc_pkg::size_t        s_object_size,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_hit,
    output atc_pkg::slot_t        m_slot,
    output atc_pkg::size_t        m_found_size
);

    // Input register.
    logic            in_valid_reg;
    atc_pkg::op_t    in_op_reg;
    atc_pkg::key_t   in_key_reg;
    atc_pkg::size_t  in_size_reg;

    // Result register.
    logic            out_valid_reg;
    logic            out_hit_reg;
    atc_pkg::slot_t  out_slot_reg;
    atc_pkg::size_t  out_size_reg;
    logic            out_hit_next;
    atc_pkg::slot_t  out_slot_next;
    atc_pkg::size_t  out_size_next;

    // Tag store.
    logic [atc_pkg::ENTRIES-1:0] valid_reg;
    atc_pkg::key_t               tag_reg  [atc_pkg::ENTRIES];
    atc_pkg::size_t              size_reg [atc_pkg::ENTRIES];
    atc_pkg::age_t               age_reg  [atc_pkg::ENTRIES];

    logic                        out_load;
    logic                        advance;
    logic                        do_insert;
    logic [atc_pkg::ENTRIES-1:0] match;
    logic                        match_any;
    atc_pkg::idx_t               match_idx;
    atc_pkg::size_t              match_size;
    atc_pkg::victim_t            victim;

    // Flow control: the result register loads when empty or being drained.
    assign out_load = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_load;
    assign s_ready  = !in_valid_reg || out_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg   <= atc_pkg::op_t'(s_operation);
            in_key_reg  <= s_key;
            in_size_reg <= s_object_size;
        end
    end

    // Parallel tag compare and first-match priority encode.
    always_comb begin
        for (int i = 0; i < atc_pkg::ENTRIES; i++) begin
            match[i] = valid_reg[i] && (tag_reg[i] == in_key_reg);
        end
        match_any = |match;
        match_idx = '0;
        for (int i = atc_pkg::ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                match_idx = atc_pkg::IDX_W'(i);
            end
        end
        match_size = size_reg[match_idx];
    end

    atc_victim_sel u_victim (
        .valid_i  (valid_reg),
        .ages_i   (age_reg),
        .victim_o (victim)
    );

    assign do_insert = advance && (in_op_reg == atc_pkg::OP_INSERT) &&
                       (32'(in_size_reg) < 32'(atc_pkg::SIZE_LIMIT));

    // Result of the request in the input register.
    always_comb begin
        out_hit_next  = 1'b0;
        out_slot_next = '0;
        out_size_next = '0;
        case (in_op_reg)
            atc_pkg::OP_LOOKUP: begin
                if (match_any) begin
                    out_slot_next = atc_pkg::SLOT_W'(match_idx);
                    if (match_size != '0) begin
                        out_hit_next  = 1'b1;
                        out_size_next = match_size;
                    end
                end
            end
            atc_pkg::OP_INSERT: begin
                if (32'(in_size_reg) < 32'(atc_pkg::SIZE_LIMIT)) begin
                    out_slot_next = atc_pkg::SLOT_W'(victim.idx);
                end
            end
            default: begin
                out_slot_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_hit_reg  <= out_hit_next;
            out_slot_reg <= out_slot_next;
            out_size_reg <= out_size_next;
        end
    end

    // Valid marks: cleared at reset, set on the victim of each insert.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (do_insert) begin
            valid_reg[victim.idx] <= 1'b1;
        end
    end

    // Payload of the store: age every other valid slot (saturating) and overwrite the victim.
    always_ff @(posedge aclk) begin
        if (do_insert) begin
            for (int i = 0; i < atc_pkg::ENTRIES; i++) begin
                if (atc_pkg::IDX_W'(i) == victim.idx) begin
                    tag_reg[i]  <= in_key_reg;
                    size_reg[i] <= in_size_reg;
                    age_reg[i]  <= '0;
                end else if (valid_reg[i] && (age_reg[i] < atc_pkg::AGE_TOP)) begin
                    age_reg[i] <= age_reg[i] + atc_pkg::AGE_W'(1);
                end
            end
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_hit        = out_hit_reg;
    assign m_slot       = out_slot_reg;
    assign m_found_size = out_size_reg;

    // A hit always carries a nonzero size, and a miss carries none.
    a_hit_size : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_hit == (m_found_size != '0)))
        else $error("hit flag and found size disagree");

    // An insert result never reports a hit.
    a_insert_no_hit : assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (in_op_reg == atc_pkg::OP_INSERT)) |=> !m_hit)
        else $error("insert produced a hit");

    // The slot written by an insert is marked valid afterwards.
    a_victim_valid : assert property (@(posedge aclk) disable iff (!aresetn)
        do_insert |=> valid_reg[$past(victim.idx)])
        else $error("inserted slot not marked valid");

    // The input side stalls only behind a held result.
    a_stall_cause : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && in_valid_reg))
        else $error("input stalled without a held result");

    // A result beat that is held keeps its payload.
    a_hold_result : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_slot) && $stable(m_found_size)))
        else $error("held result changed");

endmodule
